// ===== rtl/tpsa_pkg.sv =====
package tpsa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LOW_DEPTH  = 256;
  localparam int unsigned HIGH_DEPTH = 4096;

  // count widths hold the depth itself; index widths address one entry
  localparam int unsigned LOW_CW  = $clog2(LOW_DEPTH + 1);
  localparam int unsigned HIGH_CW = $clog2(HIGH_DEPTH + 1);
  localparam int unsigned LOW_AW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int unsigned HIGH_AW = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;

  localparam logic [LOW_CW-1:0]  LOW_FULL  = LOW_CW'(LOW_DEPTH);
  localparam logic [HIGH_CW-1:0] HIGH_FULL = HIGH_CW'(HIGH_DEPTH);

  localparam logic [ADDR_W-1:0] BOUNDARY_RST = 32'h0010_0000;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_LOW = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE      = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/two_pool_page_stack_allocator.sv =====
// Results are registered: an accepted request shows its result in the next cycle.
// Throughput: one request per cycle, alloc and free in any mix, while no held result
//   is stalled; top entries stay ready via an early RAM read plus a write bypass.
// Reset: both free counts clear to zero, the boundary returns to 0x100000, and the
//   output register empties; the stack RAMs are not cleared and need no sweep.
module two_pool_page_stack_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // boundary register
  input  logic                              cfg_we_i,
  input  logic [tpsa_pkg::ADDR_W-1:0]       cfg_wdata_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tpsa_pkg::FUNC_W-1:0]       func_i,
  input  logic [tpsa_pkg::ADDR_W-1:0]       page_addr_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tpsa_pkg::ADDR_W-1:0]       page_out_o,
  output logic [tpsa_pkg::STATUS_W-1:0]     status_o,
  output logic [tpsa_pkg::LOW_CW-1:0]       low_free_o,
  output logic [tpsa_pkg::HIGH_CW-1:0]      high_free_o
);

  import tpsa_pkg::*;

  // control state
  logic [ADDR_W-1:0]   bound_q;
  logic [LOW_CW-1:0]   low_cnt_q, low_cnt_d;
  logic [HIGH_CW-1:0]  high_cnt_q, high_cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                low_hit_q, high_hit_q;

  // payload
  logic [ADDR_W-1:0]   low_wd_q, high_wd_q;
  logic [ADDR_W-1:0]   page_q, page_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [LOW_CW-1:0]   low_free_q;
  logic [HIGH_CW-1:0]  high_free_q;

  // stack RAM ports
  logic                low_we, high_we;
  logic [LOW_AW-1:0]   low_waddr, low_raddr;
  logic [HIGH_AW-1:0]  high_waddr, high_raddr;
  logic [ADDR_W-1:0]   low_rdata, high_rdata;
  logic [ADDR_W-1:0]   low_top, high_top;

  logic fire;

  // Take a new request whenever the result register is empty or being drained.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign fire       = in_valid_i & ~in_stall_o;

  // Top of each stack. The RAM was read last cycle at (count - 1); if that
  // cycle pushed, the RAM returned the stale word, so take the pushed page.
  assign low_top  = low_hit_q  ? low_wd_q  : low_rdata;
  assign high_top = high_hit_q ? high_wd_q : high_rdata;

  always_comb begin
    low_cnt_d  = low_cnt_q;
    high_cnt_d = high_cnt_q;
    low_we     = 1'b0;
    high_we    = 1'b0;
    page_d     = '0;
    status_d   = ST_OK;
    if (fire) begin
      unique case (func_i)
        FUNC_ALLOC: begin
          // prefer high memory, fall back to the low pool
          if (high_cnt_q != '0) begin
            page_d     = high_top;
            high_cnt_d = high_cnt_q - HIGH_CW'(1);
          end else if (low_cnt_q != '0) begin
            page_d    = low_top;
            low_cnt_d = low_cnt_q - LOW_CW'(1);
          end else begin
            status_d = ST_EMPTY;
          end
        end
        FUNC_ALLOC_LOW: begin
          if (low_cnt_q != '0) begin
            page_d    = low_top;
            low_cnt_d = low_cnt_q - LOW_CW'(1);
          end else begin
            status_d = ST_EMPTY;
          end
        end
        FUNC_FREE: begin
          // route by address; drop the push on a full stack
          if (page_addr_i < bound_q) begin
            if (low_cnt_q != LOW_FULL) begin
              low_we    = 1'b1;
              low_cnt_d = low_cnt_q + LOW_CW'(1);
            end else begin
              status_d = ST_FULL;
            end
          end else begin
            if (high_cnt_q != HIGH_FULL) begin
              high_we    = 1'b1;
              high_cnt_d = high_cnt_q + HIGH_CW'(1);
            end else begin
              status_d = ST_FULL;
            end
          end
        end
        default: begin
          // unused code: no state change, ok status, zero page
        end
      endcase
    end
  end

  // Push writes at the old count; the read always targets the new top so it
  // is ready for a pop in the next cycle. An empty stack wraps the read
  // address, and that word is never used.
  assign low_waddr  = low_cnt_q[LOW_AW-1:0];
  assign high_waddr = high_cnt_q[HIGH_AW-1:0];
  assign low_raddr  = low_cnt_d[LOW_AW-1:0] - LOW_AW'(1);
  assign high_raddr = high_cnt_d[HIGH_AW-1:0] - HIGH_AW'(1);

  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q     <= BOUNDARY_RST;
      low_cnt_q   <= '0;
      high_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      low_hit_q   <= 1'b0;
      high_hit_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bound_q <= cfg_wdata_i;
      end
      low_cnt_q   <= low_cnt_d;
      high_cnt_q  <= high_cnt_d;
      out_valid_q <= out_valid_d;
      low_hit_q   <= low_we;
      high_hit_q  <= high_we;
    end
  end

  // payload registers: bypass words and the result
  always_ff @(posedge clk_i) begin
    if (low_we) begin
      low_wd_q <= page_addr_i;
    end
    if (high_we) begin
      high_wd_q <= page_addr_i;
    end
    if (fire) begin
      page_q      <= page_d;
      status_q    <= status_d;
      low_free_q  <= low_cnt_d;
      high_free_q <= high_cnt_d;
    end
  end

  tpsa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LOW_DEPTH)
  ) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (low_we),
    .waddr_i (low_waddr),
    .wdata_i (page_addr_i),
    .raddr_i (low_raddr),
    .rdata_o (low_rdata)
  );

  tpsa_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (HIGH_DEPTH)
  ) u_high_ram (
    .clk_i   (clk_i),
    .we_i    (high_we),
    .waddr_i (high_waddr),
    .wdata_i (page_addr_i),
    .raddr_i (high_raddr),
    .rdata_o (high_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign page_out_o  = page_q;
  assign status_o    = status_q;
  assign low_free_o  = low_free_q;
  assign high_free_o = high_free_q;

  // counts never pass the stack depths
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_cnt_q <= LOW_FULL) && (high_cnt_q <= HIGH_FULL))
    else $error("free count beyond stack depth");

  // an accepted request always leaves a result waiting
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("accepted request produced no result");

  // a general allocate with both pools empty reports empty and page zero
  a_empty_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (func_i == FUNC_ALLOC) && (low_cnt_q == '0) && (high_cnt_q == '0)
    |=> (status_o == ST_EMPTY) && (page_out_o == '0))
    else $error("allocate from empty pools not flagged");

  // a successful free grows exactly one pool by one
  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (func_i == FUNC_FREE) && (status_d == ST_OK)
    |=> ({1'b0, low_cnt_q} + {1'b0, high_cnt_q}
         == $past({1'b0, low_cnt_q} + {1'b0, high_cnt_q}) + 1'b1))
    else $error("free did not add one page");

endmodule

// ===== rtl/tpsa_ram.sv =====
module tpsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/two_pool_page_stack_allocator_test.sv =====
`timescale 1ns / 100ps

module two_pool_page_stack_allocator_test;
  import tpsa_pkg::*;

  // func 3 has no meaning: the block answers with page 0, status ok and the counts
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DIRECTED_ROWS = 21;

  typedef struct packed {
    logic [ADDR_W-1:0]   page;
    logic [STATUS_W-1:0] status;
    logic [LOW_CW-1:0]   low_free;
    logic [HIGH_CW-1:0]  high_free;
  } page_reply_t;

  // one directed request; typed rows carry their reply, the rest go to the predictor
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    page_reply_t       reply;
  } directed_row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [ADDR_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i      = FUNC_ALLOC;
  logic [ADDR_W-1:0]   page_addr_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [ADDR_W-1:0]   page_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [LOW_CW-1:0]   low_free_o;
  logic [HIGH_CW-1:0]  high_free_o;

  two_pool_page_stack_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .page_addr_i (page_addr_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .page_out_o  (page_out_o),
    .status_o    (status_o),
    .low_free_o  (low_free_o),
    .high_free_o (high_free_o)
  );

  // Predictor state: its own copy of both free-page stacks and the boundary.
  logic [ADDR_W-1:0] low_pages  [LOW_DEPTH];
  logic [ADDR_W-1:0] high_pages [HIGH_DEPTH];
  int unsigned       low_pages_held  = 0;
  int unsigned       high_pages_held = 0;
  logic [ADDR_W-1:0] pool_boundary   = BOUNDARY_RST;

  // Replies predicted for accepted requests, oldest first.
  page_reply_t predicted_replies [$];

  int req_gap_pct      = 0;  // chance that the sender idles before a request
  int result_stall_pct = 0;  // chance that the receiver stalls in a cycle
  int mismatches       = 0;
  int unsigned cycle_count = 0;

  // Each row is checked in order against the reset boundary 0x100000.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // both pools empty right after reset
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0, 13'd0}},
    '{FUNC_ALLOC_LOW, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0, 13'd0}},
    '{FUNC_UNUSED,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    9'd0, 13'd0}},
    // page zero, just below, at and far above the boundary
    '{FUNC_FREE,      32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    9'd1, 13'd0}},
    '{FUNC_FREE,      32'h000F_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    9'd2, 13'd0}},
    '{FUNC_FREE,      32'h0010_0000, 1'b1, '{32'h0000_0000, ST_OK,    9'd2, 13'd1}},
    '{FUNC_FREE,      32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    9'd2, 13'd2}},
    '{FUNC_UNUSED,    32'h0010_0000, 1'b1, '{32'h0000_0000, ST_OK,    9'd2, 13'd2}},
    // pop back in stack order; general allocate falls back to low
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, ST_OK,    9'd2, 13'd1}},
    '{FUNC_ALLOC_LOW, 32'hFFFF_FFFF, 1'b1, '{32'h000F_FFFF, ST_OK,    9'd1, 13'd1}},
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'h0010_0000, ST_OK,    9'd1, 13'd0}},
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,    9'd0, 13'd0}},
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0, 13'd0}},
    // low-only allocate finds nothing while the high pool has pages
    '{FUNC_FREE,      32'hAAAA_AAAA, 1'b1, '{32'h0000_0000, ST_OK,    9'd0, 13'd1}},
    '{FUNC_ALLOC_LOW, 32'h5555_5555, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0, 13'd1}},
    '{FUNC_FREE,      32'h5555_5555, 1'b1, '{32'h0000_0000, ST_OK,    9'd0, 13'd2}},
    '{FUNC_FREE,      32'h0001_2345, 1'b0, '0},
    '{FUNC_ALLOC,     32'h0000_0000, 1'b0, '0},
    '{FUNC_ALLOC_LOW, 32'h0000_0000, 1'b0, '0},
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'hAAAA_AAAA, ST_OK,    9'd0, 13'd0}},
    '{FUNC_ALLOC,     32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 9'd0, 13'd0}}
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the predicted pools and return the reply it causes.
  function automatic page_reply_t apply_page_request(input logic [FUNC_W-1:0] func,
                                                     input logic [ADDR_W-1:0] addr);
    page_reply_t reply;
    reply        = '0;
    reply.status = ST_OK;
    case (func)
      FUNC_ALLOC: begin
        if (high_pages_held != 0) begin
          high_pages_held = high_pages_held - 1;
          reply.page      = high_pages[high_pages_held];
        end else if (low_pages_held != 0) begin
          low_pages_held = low_pages_held - 1;
          reply.page     = low_pages[low_pages_held];
        end else begin
          reply.status = ST_EMPTY;
        end
      end
      FUNC_ALLOC_LOW: begin
        if (low_pages_held != 0) begin
          low_pages_held = low_pages_held - 1;
          reply.page     = low_pages[low_pages_held];
        end else begin
          reply.status = ST_EMPTY;
        end
      end
      FUNC_FREE: begin
        if (addr < pool_boundary) begin
          if (low_pages_held < LOW_DEPTH) begin
            low_pages[low_pages_held] = addr;
            low_pages_held            = low_pages_held + 1;
          end else begin
            reply.status = ST_FULL;
          end
        end else begin
          if (high_pages_held < HIGH_DEPTH) begin
            high_pages[high_pages_held] = addr;
            high_pages_held             = high_pages_held + 1;
          end else begin
            reply.status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
    reply.low_free  = LOW_CW'(low_pages_held);
    reply.high_free = HIGH_CW'(high_pages_held);
    return reply;
  endfunction

  // Pick a page address around the current boundary, with edges often.
  function automatic logic [ADDR_W-1:0] pick_page();
    logic [ADDR_W-1:0] addr;
    case ($urandom_range(5))
      0: addr = $urandom;
      1: addr = (pool_boundary == 0) ? $urandom : $urandom_range(pool_boundary - 1, 0);
      2: addr = $urandom_range(32'hFFFF_FFFF, pool_boundary);
      3: addr = pool_boundary;
      4: addr = pool_boundary - 1;
      default: addr = $urandom & 32'hFFFF_F000;
    endcase
    return addr;
  endfunction

  // Drive one request, hold it until accepted, then record its reply.
  // Valid stays high on return so back-to-back requests need no second assignment.
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr,
                              input logic typed, input page_reply_t typed_reply);
    page_reply_t reply;
    if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < req_gap_pct);
    end
    in_valid_i  <= 1'b1;
    func_i      <= func;
    page_addr_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    reply = apply_page_request(func, addr);
    predicted_replies.push_back(typed ? typed_reply : reply);
  endtask

  // Drop valid and hold off until every predicted reply has come back.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Move the boundary only with the block idle.
  task automatic write_boundary(input logic [ADDR_W-1:0] value);
    drain_replies();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    pool_boundary  = value;
  endtask

  // Random traffic in bursts that lean toward freeing, allocating or a mix,
  // so the stacks grow deep and also run dry.
  task automatic run_traffic(input int unsigned n_requests);
    int unsigned sent;
    int unsigned burst;
    int unsigned free_pct;
    int unsigned pick;
    logic [FUNC_W-1:0] func;
    sent = 0;
    while (sent < n_requests) begin
      burst = $urandom_range(16, 1);
      case ($urandom_range(2))
        0:       free_pct = 80;
        1:       free_pct = 20;
        default: free_pct = 50;
      endcase
      repeat (burst) begin
        pick = $urandom_range(99);
        if (pick < free_pct) func = FUNC_FREE;
        else if (pick < 95) func = $urandom_range(1) ? FUNC_ALLOC : FUNC_ALLOC_LOW;
        else func = FUNC_UNUSED;
        send_request(func, pick_page(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Push the low stack a few pages past full, then pause with it full.
  task automatic overflow_pools();
    int unsigned fill;
    fill = LOW_DEPTH - low_pages_held + 3;
    repeat (fill)
      send_request(FUNC_FREE, $urandom_range(32'h7FFF_FFFF, 0), 1'b0, '0);
    drain_replies();
  endtask

  // Stall the result side at the current rate.
  always @(posedge clk_i) begin
    out_stall_i <= (result_stall_pct != 0) && ($urandom_range(99) < result_stall_pct);
  end

  // Compare each accepted reply with the oldest prediction.
  always @(posedge clk_i) begin : check_replies
    page_reply_t want;
    page_reply_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{page_out_o, status_o, low_free_o, high_free_o};
      if (predicted_replies.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: reply with none pending: page=%h status=%0d low=%0d high=%0d",
                   $realtime, got.page, got.status, got.low_free, got.high_free);
        mismatches++;
      end else begin
        want = predicted_replies.pop_front();
        if (got.page !== want.page || got.status !== want.status ||
            got.low_free !== want.low_free || got.high_free !== want.high_free) begin
          if (mismatches < 10)
            $display("%0t: reply mismatch: expected page=%h status=%0d low=%0d high=%0d, %s",
                     $realtime, want.page, want.status, want.low_free, want.high_free,
                     $sformatf("got page=%h status=%0d low=%0d high=%0d",
                               got.page, got.status, got.low_free, got.high_free));
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset boundary, no idling.
    for (int unsigned row = 0; row < DIRECTED_ROWS; row++)
      send_request(directed_rows[row].func, directed_rows[row].addr,
                   directed_rows[row].typed, directed_rows[row].reply);

    // Random traffic: one idling pattern and one boundary per phase.
    run_traffic(40);

    write_boundary(32'h0000_0000);
    req_gap_pct = 61;
    run_traffic(40);

    write_boundary(32'hFFFF_FFFF);
    req_gap_pct      = 0;
    result_stall_pct = 61;
    run_traffic(40);

    write_boundary($urandom);
    req_gap_pct      = 23;
    result_stall_pct = 23;
    run_traffic(40);

    // Split the address space in half and run the low stack past full.
    write_boundary(32'h8000_0000);
    overflow_pools();

    write_boundary(BOUNDARY_RST);
    req_gap_pct      = 0;
    result_stall_pct = 0;
    run_traffic(20);

    drain_replies();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
